FILE: src/json_string_unescape_utf8_top_macros.svh
// assertion helpers shared by the decoder modules
`ifndef JSON_STRING_UNESCAPE_UTF8_TOP_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define JSU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/jsu_pkg.sv
package jsu_pkg;

    // result kinds, also used as the terminator tag of a run
    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    // decoder phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BODY,
        PH_ESC,
        PH_HEX1,
        PH_AFTER_HIGH,
        PH_HIGH_ESC,
        PH_HEX2,
        PH_SKIP
    } t_phase;

    typedef logic [7:0] t_byte;

    localparam int MAX_BYTES = 6;

    // one run of results caused by one input byte
    typedef struct packed {
        logic [2:0]                  n_data;
        t_kind                       term;
        t_byte [MAX_BYTES-1:0]       data;
    } t_desc;

    // queue status toward both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    typedef struct packed {
        logic [2:0]  len;
        t_byte [3:0] b;
    } t_utf8;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    typedef struct packed {
        logic  ok;
        t_byte val;
    } t_esc;

    // characters of interest
    localparam t_byte CH_QUOTE  = 8'h22;
    localparam t_byte CH_BSLASH = 8'h5c;
    localparam t_byte CH_SLASH  = 8'h2f;
    localparam t_byte CH_B      = 8'h62;
    localparam t_byte CH_F      = 8'h66;
    localparam t_byte CH_N      = 8'h6e;
    localparam t_byte CH_R      = 8'h72;
    localparam t_byte CH_T      = 8'h74;
    localparam t_byte CH_U      = 8'h75;

    // code point ranges
    localparam logic [15:0] SURR_HI_FIRST = 16'hd800;
    localparam logic [15:0] SURR_HI_LAST  = 16'hdbff;
    localparam logic [15:0] SURR_LO_FIRST = 16'hdc00;
    localparam logic [15:0] SURR_LO_LAST  = 16'hdfff;
    localparam logic [20:0] CP_SUPP_BASE  = 21'h10000;
    localparam logic [20:0] UTF8_MAX1     = 21'h7f;
    localparam logic [20:0] UTF8_MAX2     = 21'h7ff;
    localparam logic [20:0] UTF8_MAX3     = 21'hffff;

    // utf-8 encoding, first byte in b[0]
    function automatic t_utf8 utf8_enc(input logic [20:0] cp);
        t_utf8 r;
        r.len = 3'd0;
        r.b   = '0;
        if (cp <= UTF8_MAX1) begin
            r.len  = 3'd1;
            r.b[0] = cp[7:0];
        end else if (cp <= UTF8_MAX2) begin
            r.len  = 3'd2;
            r.b[0] = {3'b110, cp[10:6]};
            r.b[1] = {2'b10, cp[5:0]};
        end else if (cp <= UTF8_MAX3) begin
            r.len  = 3'd3;
            r.b[0] = {4'b1110, cp[15:12]};
            r.b[1] = {2'b10, cp[11:6]};
            r.b[2] = {2'b10, cp[5:0]};
        end else begin
            r.len  = 3'd4;
            r.b[0] = {5'b11110, cp[20:18]};
            r.b[1] = {2'b10, cp[17:12]};
            r.b[2] = {2'b10, cp[11:6]};
            r.b[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

    // hex digit value
    function automatic t_hex hex_digit(input t_byte b);
        t_hex  r;
        t_byte d;
        r.ok  = 1'b0;
        r.val = 4'd0;
        d     = 8'h00;
        if (b >= 8'h30 && b <= 8'h39) begin
            d = b - 8'h30;
            r.ok = 1'b1;
        end else if (b >= 8'h61 && b <= 8'h66) begin
            d = b - 8'h57;
            r.ok = 1'b1;
        end else if (b >= 8'h41 && b <= 8'h46) begin
            d = b - 8'h37;
            r.ok = 1'b1;
        end
        r.val = d[3:0];
        return r;
    endfunction

    // single-character escapes
    function automatic t_esc esc_map(input t_byte b);
        t_esc r;
        r.ok  = 1'b1;
        r.val = b;
        unique case (b)
            CH_QUOTE, CH_BSLASH, CH_SLASH: r.val = b;
            CH_B:    r.val = 8'h08;
            CH_F:    r.val = 8'h0c;
            CH_N:    r.val = 8'h0a;
            CH_R:    r.val = 8'h0d;
            CH_T:    r.val = 8'h09;
            default: r.ok  = 1'b0;
        endcase
        return r;
    endfunction

endpackage

FILE: src/jsu_front.sv
`include "json_string_unescape_utf8_top_macros.svh"

module jsu_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic [7:0]      i_in_byte,
    input  logic            i_end_of_text,
    output logic            o_push,
    output jsu_pkg::t_desc  o_desc
);

    typedef enum logic [1:0] {
        MAIN_NONE,
        MAIN_RAW,
        MAIN_CP
    } t_main;

    jsu_pkg::t_phase r_phase, n_phase;
    logic [1:0]      r_hex_count, n_hex_count;
    logic [15:0]     r_accum, n_accum;
    logic [9:0]      r_pending, n_pending;

    // byte classification
    logic            is_quote, is_bslash, is_u;
    jsu_pkg::t_hex   hx;
    jsu_pkg::t_esc   esc;
    logic            fourth;
    logic [15:0]     acc_new;
    logic            acc_hi_surr, acc_lo_surr;
    logic [20:0]     pair_cp;

    assign is_quote    = (i_in_byte == jsu_pkg::CH_QUOTE);
    assign is_bslash   = (i_in_byte == jsu_pkg::CH_BSLASH);
    assign is_u        = (i_in_byte == jsu_pkg::CH_U);
    assign hx          = jsu_pkg::hex_digit(i_in_byte);
    assign esc         = jsu_pkg::esc_map(i_in_byte);
    assign fourth      = hx.ok && (r_hex_count == 2'd3);
    assign acc_new     = {r_accum[11:0], hx.val};
    assign acc_hi_surr = (acc_new >= jsu_pkg::SURR_HI_FIRST) && (acc_new <= jsu_pkg::SURR_HI_LAST);
    assign acc_lo_surr = (acc_new >= jsu_pkg::SURR_LO_FIRST) && (acc_new <= jsu_pkg::SURR_LO_LAST);
    assign pair_cp     = jsu_pkg::CP_SUPP_BASE + {1'b0, r_pending, acc_new[9:0]};

    // result selection per phase
    logic            emit_hi;
    t_main           main_sel;
    logic [20:0]     main_cp;
    jsu_pkg::t_kind  term_raw, term_fin;

    always_comb begin
        emit_hi  = 1'b0;
        main_sel = MAIN_NONE;
        main_cp  = '0;
        term_raw = jsu_pkg::KIND_DATA;
        unique case (r_phase)
            jsu_pkg::PH_IDLE: begin
                if (!is_quote) term_raw = jsu_pkg::KIND_ERR;
            end
            jsu_pkg::PH_BODY: begin
                if (is_quote) term_raw = jsu_pkg::KIND_DONE;
                else if (!is_bslash) main_sel = MAIN_RAW;
            end
            jsu_pkg::PH_ESC: begin
                if (esc.ok) begin
                    main_sel = MAIN_CP;
                    main_cp  = {13'd0, esc.val};
                end else if (!is_u) begin
                    term_raw = jsu_pkg::KIND_ERR;
                end
            end
            jsu_pkg::PH_HEX1: begin
                if (!hx.ok) begin
                    term_raw = jsu_pkg::KIND_ERR;
                end else if (fourth && !acc_hi_surr) begin
                    main_sel = MAIN_CP;
                    main_cp  = {5'd0, acc_new};
                end
            end
            jsu_pkg::PH_AFTER_HIGH: begin
                if (!is_bslash) begin
                    emit_hi = 1'b1;
                    if (is_quote) term_raw = jsu_pkg::KIND_DONE;
                    else main_sel = MAIN_RAW;
                end
            end
            jsu_pkg::PH_HIGH_ESC: begin
                if (!is_u) begin
                    emit_hi = 1'b1;
                    if (esc.ok) begin
                        main_sel = MAIN_CP;
                        main_cp  = {13'd0, esc.val};
                    end else begin
                        term_raw = jsu_pkg::KIND_ERR;
                    end
                end
            end
            jsu_pkg::PH_HEX2: begin
                if (!hx.ok) begin
                    term_raw = jsu_pkg::KIND_ERR;
                end else if (fourth) begin
                    if (acc_lo_surr) begin
                        main_sel = MAIN_CP;
                        main_cp  = pair_cp;
                    end else begin
                        emit_hi = 1'b1;
                        if (!acc_hi_surr) begin
                            main_sel = MAIN_CP;
                            main_cp  = {5'd0, acc_new};
                        end
                    end
                end
            end
            jsu_pkg::PH_SKIP: begin
                term_raw = jsu_pkg::KIND_DATA;
            end
            default: term_raw = jsu_pkg::KIND_DATA;
        endcase
    end

    // end of text before the closing quote is an error
    assign term_fin = (term_raw == jsu_pkg::KIND_DATA && i_end_of_text &&
                       r_phase != jsu_pkg::PH_SKIP) ? jsu_pkg::KIND_ERR : term_raw;

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_hex_count = r_hex_count;
        n_accum     = r_accum;
        n_pending   = r_pending;
        if (i_take) begin
            unique case (r_phase)
                jsu_pkg::PH_IDLE: begin
                    if (is_quote) begin
                        n_phase     = jsu_pkg::PH_BODY;
                        n_hex_count = '0;
                        n_accum     = '0;
                        n_pending   = '0;
                    end
                end
                jsu_pkg::PH_BODY, jsu_pkg::PH_AFTER_HIGH: begin
                    if (is_bslash) begin
                        n_phase = (r_phase == jsu_pkg::PH_BODY) ? jsu_pkg::PH_ESC
                                                                : jsu_pkg::PH_HIGH_ESC;
                    end else begin
                        n_phase = jsu_pkg::PH_BODY;
                    end
                end
                jsu_pkg::PH_ESC, jsu_pkg::PH_HIGH_ESC: begin
                    if (is_u) begin
                        n_phase     = (r_phase == jsu_pkg::PH_ESC) ? jsu_pkg::PH_HEX1
                                                                   : jsu_pkg::PH_HEX2;
                        n_hex_count = '0;
                        n_accum     = '0;
                    end else begin
                        n_phase = jsu_pkg::PH_BODY;
                    end
                end
                jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
                    if (hx.ok) begin
                        n_accum     = acc_new;
                        n_hex_count = r_hex_count + 2'd1;
                        if (fourth) begin
                            if (r_phase == jsu_pkg::PH_HEX2 && acc_lo_surr) begin
                                n_phase = jsu_pkg::PH_BODY;
                            end else if (acc_hi_surr) begin
                                n_phase   = jsu_pkg::PH_AFTER_HIGH;
                                n_pending = acc_new[9:0];
                            end else begin
                                n_phase = jsu_pkg::PH_BODY;
                            end
                        end
                    end
                end
                jsu_pkg::PH_SKIP: begin
                    if (i_end_of_text) n_phase = jsu_pkg::PH_IDLE;
                end
                default: n_phase = jsu_pkg::PH_SKIP;
            endcase
            if (term_fin != jsu_pkg::KIND_DATA) begin
                n_phase = i_end_of_text ? jsu_pkg::PH_IDLE : jsu_pkg::PH_SKIP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= jsu_pkg::PH_IDLE;
            r_hex_count <= '0;
            r_accum     <= '0;
            r_pending   <= '0;
        end else begin
            r_phase     <= n_phase;
            r_hex_count <= n_hex_count;
            r_accum     <= n_accum;
            r_pending   <= n_pending;
        end
    end

    // assemble the run: optional lone high surrogate, then the main part
    jsu_pkg::t_utf8 hi_enc, cp_enc, main_enc;
    logic [2:0]     data_len;

    assign hi_enc = jsu_pkg::utf8_enc({5'd0, jsu_pkg::SURR_HI_FIRST[15:10], r_pending});
    assign cp_enc = jsu_pkg::utf8_enc(main_cp);

    always_comb begin
        main_enc = '0;
        unique case (main_sel)
            MAIN_NONE: main_enc = '0;
            MAIN_RAW: begin
                main_enc.len  = 3'd1;
                main_enc.b[0] = i_in_byte;
            end
            MAIN_CP:  main_enc = cp_enc;
            default:  main_enc = '0;
        endcase
    end

    assign data_len = (emit_hi ? 3'd3 : 3'd0) + main_enc.len;

    always_comb begin
        o_desc.term   = term_fin;
        o_desc.n_data = (term_fin == jsu_pkg::KIND_ERR) ? 3'd0 : data_len;
        if (emit_hi) begin
            o_desc.data = {main_enc.b[2], main_enc.b[1], main_enc.b[0],
                           hi_enc.b[2], hi_enc.b[1], hi_enc.b[0]};
        end else begin
            o_desc.data = {8'h00, 8'h00, main_enc.b[3], main_enc.b[2],
                           main_enc.b[1], main_enc.b[0]};
        end
    end

    assign o_push = i_take && (o_desc.n_data != 3'd0 || term_fin != jsu_pkg::KIND_DATA);

    // an error run never carries data bytes
    `JSU_ASSERT_NOW(a_err_no_data, i_clk, i_rst_n, o_push && o_desc.term == jsu_pkg::KIND_ERR, o_desc.n_data == 3'd0, "error run carries data")
    // a run ending in done or error without end of text skips the rest
    `JSU_ASSERT_NEXT(a_term_skip, i_clk, i_rst_n, o_push && o_desc.term != jsu_pkg::KIND_DATA && !i_end_of_text, r_phase == jsu_pkg::PH_SKIP, "no skip after terminator")

endmodule

FILE: src/jsu_fifo.sv
`include "json_string_unescape_utf8_top_macros.svh"

module jsu_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  jsu_pkg::t_desc       i_desc,
    input  logic                 i_pop,
    output jsu_pkg::t_fifo_stat  o_stat,
    output jsu_pkg::t_desc       o_head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    jsu_pkg::t_desc   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (do_pop)  r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (do_push && !do_pop)      r_count <= r_count + 1'b1;
            else if (do_pop && !do_push) r_count <= r_count - 1'b1;
        end
    end

    // run storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_desc;
    end

    // a pushed run is visible the next cycle
    `JSU_ASSERT_NEXT(a_push_visible, i_clk, i_rst_n, do_push && !do_pop, !o_stat.empty, "pushed run lost")

endmodule

FILE: src/jsu_back.sv
`include "json_string_unescape_utf8_top_macros.svh"

module jsu_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  jsu_pkg::t_fifo_stat  i_stat,
    input  jsu_pkg::t_desc       i_head,
    input  logic                 i_pop,
    output logic                 o_run_done,
    output logic [7:0]           o_out_byte,
    output logic [1:0]           o_kind,
    output logic                 o_last_of_run
);

    logic [2:0] r_idx;
    logic [2:0] total;
    logic       beat;

    // results in the head run, terminator included
    assign total = i_head.n_data + {2'd0, (i_head.term != jsu_pkg::KIND_DATA)};
    assign beat  = i_pop && !i_stat.empty;

    // current result of the head run
    always_comb begin
        if (r_idx < i_head.n_data) begin
            o_out_byte = i_head.data[r_idx];
            o_kind     = jsu_pkg::KIND_DATA;
        end else begin
            o_out_byte = 8'h00;
            o_kind     = i_head.term;
        end
    end

    assign o_last_of_run = ((r_idx + 3'd1) == total);
    assign o_run_done    = beat && o_last_of_run;

    // walk through the run one beat at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (beat) begin
            r_idx <= o_last_of_run ? 3'd0 : r_idx + 3'd1;
        end
    end

    // a waiting run always holds at least one result
    `JSU_ASSERT_NOW(a_run_nonempty, i_clk, i_rst_n, !i_stat.empty, total != 3'd0, "empty run in queue")
    // a run stays at the head until its last beat
    `JSU_ASSERT_NEXT(a_run_held, i_clk, i_rst_n, beat && !o_last_of_run, !i_stat.empty && r_idx != 3'd0, "run dropped early")

endmodule

FILE: src/json_string_unescape_utf8_top.sv
// Streaming decoder for one quoted JSON string. Bytes enter opening quote first, at up to one
// byte per cycle, and leave as UTF-8 bytes, one result per cycle while pop is high: escapes
// and \uXXXX are decoded, surrogate pairs are joined, and lone surrogates come out as three
// bytes. Each input byte gives a run of zero to six results; the last of a run has last_of_run
// set. kind is 0 for a data byte, 1 when the closing quote is seen and 2 on any fault, after
// which the data already delivered should be dropped. Bytes after completion or a fault give
// nothing until one with end_of_text, after which the next string may start. Input is taken
// every cycle while the run queue (DESC_DEPTH runs deep) has room; the output side drains one
// result per cycle while pop is high, so a byte that expands to n results occupies the output
// for all n of them, and sustained input rate is set by the mix of run lengths.
module json_string_unescape_utf8_top #(
    parameter int DESC_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_text,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_kind,
    output logic       o_last_of_run
);

    jsu_pkg::t_fifo_stat stat;
    jsu_pkg::t_desc      front_desc;
    jsu_pkg::t_desc      head_desc;
    logic                front_push;
    logic                run_done;
    logic                take;

    assign take  = push && !stat.full;
    assign full  = stat.full;
    assign empty = stat.empty;

    // classify and decode input bytes
    jsu_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .o_push        (front_push),
        .o_desc        (front_desc)
    );

    // queue of result runs
    jsu_fifo #(
        .DEPTH (DESC_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_desc  (front_desc),
        .i_pop   (run_done),
        .o_stat  (stat),
        .o_head  (head_desc)
    );

    // serialize runs into result beats
    jsu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_stat        (stat),
        .i_head        (head_desc),
        .i_pop         (pop),
        .o_run_done    (run_done),
        .o_out_byte    (o_out_byte),
        .o_kind        (o_kind),
        .o_last_of_run (o_last_of_run)
    );

endmodule

FILE: test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int TEXT_ITEMS  = 270;
    localparam int TAIL_ITEMS  = 40;

    // one byte of input text
    typedef struct {
        t_byte b;
        logic  eot;
        logic  drain;
    } t_item;

    // one decoded result
    typedef struct {
        t_byte data;
        t_kind kind;
        logic  last;
    } t_result;

    // faults injected into generated strings
    typedef enum int {
        FLT_NONE,
        FLT_NO_QUOTE,
        FLT_BAD_ESC,
        FLT_BAD_HEX,
        FLT_EARLY_END
    } t_fault;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_end_of_text = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] o_out_byte;
    logic [1:0] o_kind;
    logic       o_last_of_run;

    t_item   text_q[$];
    t_result decoded_q[$];
    t_byte   run_q[$];
    t_item   next_item;
    t_result want;

    // decoder state mirrored by the predictor
    t_phase      dec_phase = PH_IDLE;
    logic [2:0]  hex_seen = '0;
    logic [15:0] hex_accum = '0;
    logic [9:0]  high_bits = '0;

    int   n_fail = 0;
    int   cycle_cnt = 0;
    int   gap_left = 0;
    int   stall_left = 0;
    logic quiet_tail = 1'b0;

    t_byte esc_chars[8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};
    logic [15:0] cp_edges[10] = '{16'h0000, 16'h007f, 16'h0080, 16'h07ff, 16'h0800,
                                  16'hffff, 16'hd800, 16'hdbff, 16'hdc00, 16'hdfff};

    json_string_unescape_utf8_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .empty         (empty),
        .pop           (pop),
        .o_out_byte    (o_out_byte),
        .o_kind        (o_kind),
        .o_last_of_run (o_last_of_run)
    );

    always #5ns i_clk = ~i_clk;

    // value of a hex digit, -1 when not one
    function automatic int hex_val(input t_byte b);
        if (b >= "0" && b <= "9") begin
            return b - "0";
        end
        if (b >= "a" && b <= "f") begin
            return b - "a" + 10;
        end
        if (b >= "A" && b <= "F") begin
            return b - "A" + 10;
        end
        return -1;
    endfunction

    // byte named by a single-character escape, -1 when not one
    function automatic int esc_val(input t_byte b);
        case (b)
            CH_QUOTE, CH_BSLASH, CH_SLASH: return b;
            CH_B:    return 8'h08;
            CH_F:    return 8'h0c;
            CH_N:    return 8'h0a;
            CH_R:    return 8'h0d;
            CH_T:    return 8'h09;
            default: return -1;
        endcase
    endfunction

    // append one data byte to the current run
    task automatic put_byte(input t_byte b);
        run_q.insert(run_q.size(), b);
    endtask

    // append the utf-8 form of a code point to the current run
    task automatic put_utf8(input logic [20:0] cp);
        if (cp <= 21'h7f) begin
            put_byte(t_byte'(cp));
        end else if (cp <= 21'h7ff) begin
            put_byte(8'hc0 | t_byte'(cp >> 6));
            put_byte(8'h80 | t_byte'(cp & 21'h3f));
        end else if (cp <= 21'hffff) begin
            put_byte(8'he0 | t_byte'(cp >> 12));
            put_byte(8'h80 | t_byte'((cp >> 6) & 21'h3f));
            put_byte(8'h80 | t_byte'(cp & 21'h3f));
        end else begin
            put_byte(8'hf0 | t_byte'((cp >> 18) & 21'h7));
            put_byte(8'h80 | t_byte'((cp >> 12) & 21'h3f));
            put_byte(8'h80 | t_byte'((cp >> 6) & 21'h3f));
            put_byte(8'h80 | t_byte'(cp & 21'h3f));
        end
    endtask

    // held high surrogate goes out alone as three bytes
    task automatic put_high();
        put_utf8(21'(SURR_HI_FIRST) + 21'(high_bits));
    endtask

    task automatic start_code(input logic [15:0] cp);
        if (cp >= SURR_HI_FIRST && cp <= SURR_HI_LAST) begin
            high_bits = cp[9:0];
            dec_phase = PH_AFTER_HIGH;
        end else begin
            put_utf8(21'(cp));
            dec_phase = PH_BODY;
        end
    endtask

    task automatic body_byte(input t_byte b, output t_kind st);
        st = KIND_DATA;
        if (b == CH_QUOTE) begin
            st = KIND_DONE;
        end else if (b == CH_BSLASH) begin
            dec_phase = PH_ESC;
        end else begin
            put_byte(b);
            dec_phase = PH_BODY;
        end
    endtask

    task automatic esc_byte(input t_byte b, output t_kind st);
        int v;
        st = KIND_DATA;
        v = esc_val(b);
        if (b == CH_U) begin
            dec_phase = PH_HEX1;
            hex_seen  = '0;
            hex_accum = '0;
        end else if (v < 0) begin
            st = KIND_ERR;
        end else begin
            put_byte(t_byte'(v));
            dec_phase = PH_BODY;
        end
    endtask

    task automatic take_digit(input t_byte b, output bit ok);
        int d;
        d  = hex_val(b);
        ok = (d >= 0);
        if (ok) begin
            hex_accum = {hex_accum[11:0], d[3:0]};
            hex_seen  = hex_seen + 3'd1;
        end
    endtask

    // predict the results of one accepted byte
    task automatic decode_byte(input t_byte b, input logic eot);
        t_kind       st;
        bit          ok;
        logic [15:0] lo;
        t_result     res;
        st = KIND_DATA;
        run_q.delete();
        case (dec_phase)
            PH_IDLE: begin
                if (b == CH_QUOTE) begin
                    dec_phase = PH_BODY;
                    hex_seen  = '0;
                    hex_accum = '0;
                    high_bits = '0;
                end else begin
                    st = KIND_ERR;
                end
            end
            PH_BODY: body_byte(b, st);
            PH_ESC:  esc_byte(b, st);
            PH_HEX1: begin
                take_digit(b, ok);
                if (!ok) begin
                    st = KIND_ERR;
                end else if (hex_seen >= 3'd4) begin
                    start_code(hex_accum);
                end
            end
            PH_AFTER_HIGH: begin
                if (b == CH_BSLASH) begin
                    dec_phase = PH_HIGH_ESC;
                end else begin
                    put_high();
                    body_byte(b, st);
                end
            end
            PH_HIGH_ESC: begin
                if (b == CH_U) begin
                    dec_phase = PH_HEX2;
                    hex_seen  = '0;
                    hex_accum = '0;
                end else begin
                    put_high();
                    esc_byte(b, st);
                end
            end
            PH_HEX2: begin
                take_digit(b, ok);
                if (!ok) begin
                    st = KIND_ERR;
                end else if (hex_seen >= 3'd4) begin
                    lo = hex_accum;
                    if (lo >= SURR_LO_FIRST && lo <= SURR_LO_LAST) begin
                        put_utf8(CP_SUPP_BASE + 21'({high_bits, 10'd0})
                                 + 21'(lo - SURR_LO_FIRST));
                        dec_phase = PH_BODY;
                    end else begin
                        put_high();
                        start_code(lo);
                    end
                end
            end
            default: begin
                // skipping to end of text, nothing comes out
                if (eot) begin
                    dec_phase = PH_IDLE;
                end
                return;
            end
        endcase

        // end of text inside the string is a fault, and a fault drops the data
        if (st == KIND_DATA && eot) begin
            st = KIND_ERR;
        end
        if (st == KIND_ERR) begin
            run_q.delete();
        end
        foreach (run_q[k]) begin
            res = '{run_q[k], KIND_DATA, (st == KIND_DATA && k == run_q.size() - 1)};
            decoded_q.insert(decoded_q.size(), res);
        end
        if (st != KIND_DATA) begin
            res = '{8'h00, st, 1'b1};
            decoded_q.insert(decoded_q.size(), res);
            dec_phase = eot ? PH_IDLE : PH_SKIP;
        end
    endtask

    task automatic add_item(input t_byte b, input logic eot);
        t_item it;
        it = '{b, eot, 1'b0};
        text_q.insert(text_q.size(), it);
    endtask

    task automatic add_text(input string s);
        foreach (s[k]) begin
            add_item(s[k], 1'b0);
        end
    endtask

    // hex digit in random letter case
    task automatic add_digit(input logic [3:0] nib);
        if (nib < 4'd10) begin
            add_item(t_byte'("0") + nib, 1'b0);
        end else if ($urandom_range(0, 1) == 1) begin
            add_item(t_byte'("A") + nib - 8'd10, 1'b0);
        end else begin
            add_item(t_byte'("a") + nib - 8'd10, 1'b0);
        end
    endtask

    task automatic add_u(input logic [15:0] cp);
        add_item(CH_BSLASH, 1'b0);
        add_item(CH_U, 1'b0);
        for (int k = 12; k >= 0; k -= 4) begin
            add_digit(cp[k +: 4]);
        end
    endtask

    function automatic logic [15:0] rand_code();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(0, 'h7f));
            1:       return 16'($urandom_range('h80, 'h7ff));
            2:       return 16'($urandom_range('h800, 'hffff));
            3:       return 16'($urandom_range(SURR_HI_FIRST, SURR_HI_LAST));
            4:       return 16'($urandom_range(SURR_LO_FIRST, SURR_LO_LAST));
            default: return cp_edges[$urandom_range(0, 9)];
        endcase
    endfunction

    // one quoted string with random content, sometimes broken
    task automatic gen_string();
        t_fault fault;
        t_byte  b;
        fault = FLT_NONE;
        if ($urandom_range(0, 3) == 0) begin
            fault = t_fault'($urandom_range(1, 4));
        end
        if (fault == FLT_NO_QUOTE) begin
            do b = t_byte'($urandom); while (b == CH_QUOTE);
            add_item(b, 1'b0);
        end else begin
            add_item(CH_QUOTE, 1'b0);
            repeat ($urandom_range(0, 8)) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: begin
                        do b = t_byte'($urandom); while (b == CH_QUOTE || b == CH_BSLASH);
                        add_item(b, 1'b0);
                    end
                    3, 4: begin
                        add_item(CH_BSLASH, 1'b0);
                        add_item(esc_chars[$urandom_range(0, 7)], 1'b0);
                    end
                    5, 6: add_u(rand_code());
                    7: begin
                        add_u(16'($urandom_range(SURR_HI_FIRST, SURR_HI_LAST)));
                        add_u(16'($urandom_range(SURR_LO_FIRST, SURR_LO_LAST)));
                    end
                    8: begin
                        add_u(16'($urandom_range(SURR_HI_FIRST, SURR_HI_LAST)));
                        add_u(rand_code());
                    end
                    default: add_u(16'($urandom_range(SURR_HI_FIRST, SURR_HI_LAST)));
                endcase
            end
            case (fault)
                FLT_BAD_ESC: begin
                    add_item(CH_BSLASH, 1'b0);
                    do b = t_byte'($urandom); while (b == CH_U || esc_val(b) >= 0);
                    add_item(b, 1'b0);
                end
                FLT_BAD_HEX: begin
                    if ($urandom_range(0, 1) == 1) begin
                        add_u(16'($urandom_range(SURR_HI_FIRST, SURR_HI_LAST)));
                    end
                    add_item(CH_BSLASH, 1'b0);
                    add_item(CH_U, 1'b0);
                    repeat ($urandom_range(0, 3)) begin
                        add_digit(4'($urandom));
                    end
                    do b = t_byte'($urandom); while (hex_val(b) >= 0);
                    add_item(b, 1'b0);
                end
                FLT_EARLY_END: begin
                    if ($urandom_range(0, 1) == 1) begin
                        add_item(CH_BSLASH, 1'b0);
                    end
                    text_q[$].eot = 1'b1;
                    return;
                end
                default: add_item(CH_QUOTE, 1'b0);
            endcase
        end
        // end of text on the last byte, or after some trailing junk
        if ($urandom_range(0, 1) == 1) begin
            text_q[$].eot = 1'b1;
        end else begin
            repeat ($urandom_range(0, 3)) begin
                add_item(t_byte'($urandom), 1'b0);
            end
            add_item(t_byte'($urandom), 1'b1);
        end
    endtask

    // driver: one beat per handshake, random gaps, hold-off on drain marks
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                decode_byte(i_in_byte, i_end_of_text);
            end
            quiet_tail <= (text_q.size() < TAIL_ITEMS);
            if (!push || !full) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    push <= 1'b0;
                end else if (text_q.size() == 0 ||
                             (text_q[0].drain && decoded_q.size() != 0)) begin
                    push <= 1'b0;
                end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                    gap_left = $urandom_range(0, 18);
                    push <= 1'b0;
                end else begin
                    next_item = text_q.pop_front();
                    push <= 1'b1;
                    i_in_byte <= next_item.b;
                    i_end_of_text <= next_item.eot;
                end
            end
        end
    end

    // monitor: compare each popped beat with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected result byte=%02h kind=%0d last=%b",
                             $time, o_out_byte, o_kind, o_last_of_run);
                    n_fail++;
                end else begin
                    want = decoded_q.pop_front();
                    if (o_out_byte !== want.data) begin
                        $display("%0t: out_byte expected %02h got %02h",
                                 $time, want.data, o_out_byte);
                        n_fail++;
                    end
                    if (o_kind !== want.kind) begin
                        $display("%0t: kind expected %0d got %0d", $time, want.kind, o_kind);
                        n_fail++;
                    end
                    if (o_last_of_run !== want.last) begin
                        $display("%0t: last_of_run expected %b got %b",
                                 $time, want.last, o_last_of_run);
                        n_fail++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                pop <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(0, 18);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int first_rand;
        int mid_rand;
        mid_rand = 0;

        // missing opening quote, then end of text on the opening quote
        add_item("x", 1'b1);
        add_item(CH_QUOTE, 1'b1);
        // byte extremes, then a bad escape and one skipped byte
        add_item(CH_QUOTE, 1'b0);
        add_item(8'h00, 1'b0);
        add_item(8'hff, 1'b0);
        add_text("\\q");
        add_item("z", 1'b1);
        // surrogate pair, then a lone high surrogate closed by the quote
        add_text("\"\\uD83D\\uDE00\\uD800");
        add_item(CH_QUOTE, 1'b1);
        // bad hex digit
        add_text("\"\\u0");
        add_item("g", 1'b1);

        first_rand = text_q.size();
        while (text_q.size() < TEXT_ITEMS) begin
            if (mid_rand == 0 && text_q.size() > TEXT_ITEMS / 2) begin
                mid_rand = text_q.size();
            end
            gen_string();
        end
        text_q[first_rand].drain = 1'b1;
        text_q[mid_rand].drain = 1'b1;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (text_q.size() != 0 || push || decoded_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        if (n_fail == 0 && decoded_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/jsu_pkg.sv
src/jsu_front.sv
src/jsu_fifo.sv
src/jsu_back.sv
src/json_string_unescape_utf8_top.sv
test/tb.sv
